FILE: sv/chr_pkg.sv
// chr_pkg: shared types, codes and width helpers for the command history ring
// no dependencies; used by the interfaces, all modules and the checker
`timescale 1ns / 1ps
`default_nettype none

package chr_pkg;

    // fixed field widths
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int CMAX_W = 7;

    // reset value of the stream limit register
    localparam logic [CMAX_W-1:0] CMAX_RESET = 7'd63;

    // default sizes handed to the top level
    localparam int HISTORY_DEPTH_DEF = 16;
    localparam int LINE_BYTES_DEF    = 64;

    // result kinds
    localparam logic KIND_CHAR  = 1'b0;
    localparam logic KIND_EMPTY = 1'b1;

    // input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_COMMIT = 2'd1,
        CMD_PREV   = 2'd2,
        CMD_NEXT   = 2'd3
    } cmd_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP_LEN,
        ST_CMP,
        ST_COPY,
        ST_STR_LEN,
        ST_STREAM,
        ST_EMPTY
    } state_t;

    // bits for a line length, 0 .. line_bytes-1
    function automatic int len_width(input int line_bytes);
        return $clog2(line_bytes);
    endfunction

    // bits for a character index inside a line
    function automatic int idx_width(input int line_bytes);
        return (line_bytes > 2) ? $clog2(line_bytes - 1) : 1;
    endfunction

    // bits for a ring slot
    function automatic int slot_width(input int history_depth);
        return (history_depth > 1) ? $clog2(history_depth) : 1;
    endfunction

    // bits for an entry count, 0 .. history_depth
    function automatic int cnt_width(input int history_depth);
        return $clog2(history_depth + 1);
    endfunction

endpackage

`default_nettype wire

FILE: sv/chr_if.sv
// chr_if: valid/ready channel interfaces for commands, results and configuration
// depends on chr_pkg for field widths and the command type
`timescale 1ns / 1ps
`default_nettype none

// command channel
interface chr_req_if;
    logic                            valid;
    logic                            ready;
    chr_pkg::cmd_t                   command;
    logic [chr_pkg::CHAR_W-1:0]      char_in;

    modport source (output valid, output command, output char_in, input ready);
    modport sink   (input valid, input command, input char_in, output ready);
endinterface

// result channel
interface chr_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [chr_pkg::CHAR_W-1:0]      char_out;
    logic                            kind;
    logic                            last;

    modport source (output valid, output char_out, output kind, output last, input ready);
    modport sink   (input valid, input char_out, input kind, input last, output ready);
endinterface

// configuration write channel
interface chr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [chr_pkg::CMAX_W-1:0]      out_chars_max;

    modport source (output valid, output out_chars_max, input ready);
    modport sink   (input valid, input out_chars_max, output ready);
endinterface

`default_nettype wire

FILE: sv/chr_ram.sv
// chr_ram: simple dual-port ram, one write and one registered read per cycle
// depends on chr_pkg for the default width
`timescale 1ns / 1ps
`default_nettype none

module chr_ram #(
    parameter int WIDTH  = chr_pkg::CHAR_W,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/chr_seq.sv
// chr_seq: command sequencer with the shared index counter and byte compare,
// history bookkeeping and the result register; depends on chr_pkg and chr_if
`timescale 1ns / 1ps
`default_nettype none

module chr_seq #(
    parameter int HISTORY_DEPTH = chr_pkg::HISTORY_DEPTH_DEF,
    parameter int LINE_BYTES    = chr_pkg::LINE_BYTES_DEF,
    parameter int LEN_W         = chr_pkg::len_width(chr_pkg::LINE_BYTES_DEF),
    parameter int IDX_W         = chr_pkg::idx_width(chr_pkg::LINE_BYTES_DEF),
    parameter int SLOT_W        = chr_pkg::slot_width(chr_pkg::HISTORY_DEPTH_DEF)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    chr_req_if.sink                       req,
    chr_rsp_if.source                     rsp,
    chr_cfg_if.sink                       cfg,
    // staging line ram
    output logic                          stg_we,
    output logic [IDX_W-1:0]              stg_waddr,
    output logic [chr_pkg::CHAR_W-1:0]    stg_wdata,
    output logic                          stg_re,
    output logic [IDX_W-1:0]              stg_raddr,
    input  logic [chr_pkg::CHAR_W-1:0]    stg_rdata,
    // line store ram
    output logic                          line_we,
    output logic [SLOT_W+IDX_W-1:0]       line_waddr,
    output logic [chr_pkg::CHAR_W-1:0]    line_wdata,
    output logic                          line_re,
    output logic [SLOT_W+IDX_W-1:0]       line_raddr,
    input  logic [chr_pkg::CHAR_W-1:0]    line_rdata,
    // entry length ram
    output logic                          len_we,
    output logic [SLOT_W-1:0]             len_waddr,
    output logic [LEN_W-1:0]              len_wdata,
    output logic                          len_re,
    output logic [SLOT_W-1:0]             len_raddr,
    input  logic [LEN_W-1:0]              len_rdata
);

    localparam int CNT_W = chr_pkg::cnt_width(HISTORY_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(HISTORY_DEPTH);
    localparam logic [LEN_W-1:0]  STAGE_FULL = LEN_W'(LINE_BYTES - 1);

    chr_pkg::state_t                state_reg, state_next;
    logic [LEN_W-1:0]               idx_reg, idx_next;
    logic [LEN_W-1:0]               len_reg, len_next;
    logic                           pend_reg, pend_next;
    logic [LEN_W-1:0]               stg_len_reg, stg_len_next;
    logic                           ovf_reg, ovf_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [SLOT_W-1:0]              ws_reg, ws_next;
    logic                           active_reg, active_next;
    logic [SLOT_W-1:0]              pos_reg, pos_next;
    logic [SLOT_W-1:0]              slot_reg, slot_next;
    logic [chr_pkg::CMAX_W-1:0]     cmax_reg, cmax_next;
    logic                           out_valid_reg, out_valid_next;
    logic [chr_pkg::CHAR_W-1:0]     out_char_reg, out_char_next;
    logic                           out_kind_reg, out_kind_next;
    logic                           out_last_reg, out_last_next;

    logic                           req_fire;
    logic                           can_load;
    logic                           issue;
    logic [SLOT_W-1:0]              newest_slot;
    logic [SLOT_W-1:0]              slot_dec;
    logic [SLOT_W-1:0]              slot_inc;
    logic [SLOT_W-1:0]              ws_inc;
    logic [LEN_W-1:0]               idx_prev;
    logic [LEN_W-1:0]               stream_len;

    // ring pointer arithmetic
    assign newest_slot = (ws_reg == '0) ? LAST_SLOT : ws_reg - SLOT_W'(1);
    assign slot_dec    = (slot_reg == '0) ? LAST_SLOT : slot_reg - SLOT_W'(1);
    assign slot_inc    = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
    assign ws_inc      = (ws_reg == LAST_SLOT) ? '0 : ws_reg + SLOT_W'(1);
    assign idx_prev    = idx_reg - LEN_W'(1);

    // stored length clipped to the stream limit
    assign stream_len = (chr_pkg::CMAX_W'(len_rdata) > cmax_reg) ?
                        LEN_W'(cmax_reg) : len_rdata;

    // handshakes
    assign req.ready = (state_reg == chr_pkg::ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign can_load  = !out_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid    = out_valid_reg;
    assign rsp.char_out = out_char_reg;
    assign rsp.kind     = out_kind_reg;
    assign rsp.last     = out_last_reg;

    assign stg_wdata  = req.char_in;
    assign line_wdata = stg_rdata;
    assign len_wdata  = stg_len_reg;

    // next state, ram controls and result loading
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        pend_next      = pend_reg;
        stg_len_next   = stg_len_reg;
        ovf_next       = ovf_reg;
        count_next     = count_reg;
        ws_next        = ws_reg;
        active_next    = active_reg;
        pos_next       = pos_reg;
        slot_next      = slot_reg;
        cmax_next      = cfg.valid ? cfg.out_chars_max : cmax_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_char_next  = out_char_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        issue          = 1'b0;

        stg_we     = 1'b0;
        stg_waddr  = stg_len_reg[IDX_W-1:0];
        stg_re     = 1'b0;
        stg_raddr  = idx_reg[IDX_W-1:0];
        line_we    = 1'b0;
        line_waddr = {ws_reg, idx_prev[IDX_W-1:0]};
        line_re    = 1'b0;
        line_raddr = {newest_slot, idx_reg[IDX_W-1:0]};
        len_we     = 1'b0;
        len_waddr  = ws_reg;
        len_re     = 1'b0;
        len_raddr  = newest_slot;

        case (state_reg)
            chr_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.command)
                        chr_pkg::CMD_APPEND:
                        begin
                            if (req.char_in != '0)
                            begin
                                if (stg_len_reg < STAGE_FULL)
                                begin
                                    stg_we       = 1'b1;
                                    stg_len_next = stg_len_reg + LEN_W'(1);
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                        end
                        chr_pkg::CMD_COMMIT:
                        begin
                            idx_next  = '0;
                            pend_next = 1'b0;
                            if (stg_len_reg == '0)
                            begin
                                ovf_next = 1'b0;
                            end
                            else if (!ovf_reg && count_reg != '0)
                            begin
                                len_re     = 1'b1;
                                len_raddr  = newest_slot;
                                state_next = chr_pkg::ST_CMP_LEN;
                            end
                            else
                            begin
                                state_next = chr_pkg::ST_COPY;
                            end
                        end
                        chr_pkg::CMD_PREV:
                        begin
                            if (count_reg != '0)
                            begin
                                active_next = 1'b1;
                                if (!active_reg)
                                begin
                                    pos_next  = SLOT_W'(count_reg - CNT_W'(1));
                                    slot_next = newest_slot;
                                end
                                else if (pos_reg != '0)
                                begin
                                    pos_next  = pos_reg - SLOT_W'(1);
                                    slot_next = slot_dec;
                                end
                                len_re     = 1'b1;
                                len_raddr  = slot_next;
                                state_next = chr_pkg::ST_STR_LEN;
                            end
                        end
                        chr_pkg::CMD_NEXT:
                        begin
                            if (active_reg)
                            begin
                                if (CNT_W'(pos_reg) + CNT_W'(1) < count_reg)
                                begin
                                    pos_next   = pos_reg + SLOT_W'(1);
                                    slot_next  = slot_inc;
                                    len_re     = 1'b1;
                                    len_raddr  = slot_inc;
                                    state_next = chr_pkg::ST_STR_LEN;
                                end
                                else
                                begin
                                    active_next = 1'b0;
                                    pos_next    = '0;
                                    state_next  = chr_pkg::ST_EMPTY;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = chr_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // compare lengths: if they differ the line is new, else compare its bytes
            chr_pkg::ST_CMP_LEN:
            begin
                if (len_rdata != stg_len_reg)
                begin
                    state_next = chr_pkg::ST_COPY;
                end
                else
                begin
                    state_next = chr_pkg::ST_CMP;
                end
            end

            // byte compare against the newest entry, one byte per cycle
            chr_pkg::ST_CMP:
            begin
                issue = (idx_reg < stg_len_reg);
                if (issue)
                begin
                    stg_re     = 1'b1;
                    line_re    = 1'b1;
                    line_raddr = {newest_slot, idx_reg[IDX_W-1:0]};
                    idx_next   = idx_reg + LEN_W'(1);
                end
                pend_next = issue;
                if (pend_reg)
                begin
                    if (stg_rdata != line_rdata)
                    begin
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        state_next = chr_pkg::ST_COPY;
                    end
                    else if (!issue)
                    begin
                        // duplicate of the newest entry: drop it
                        stg_len_next = '0;
                        ovf_next     = 1'b0;
                        state_next   = chr_pkg::ST_IDLE;
                    end
                end
            end

            // copy staging line into the write slot
            chr_pkg::ST_COPY:
            begin
                issue = (idx_reg < stg_len_reg);
                if (issue)
                begin
                    stg_re   = 1'b1;
                    idx_next = idx_reg + LEN_W'(1);
                end
                pend_next = issue;
                if (pend_reg)
                begin
                    line_we = 1'b1;
                    if (!issue)
                    begin
                        len_we       = 1'b1;
                        ws_next      = ws_inc;
                        count_next   = (count_reg < FULL_COUNT) ?
                                       count_reg + CNT_W'(1) : count_reg;
                        active_next  = 1'b0;
                        pos_next     = '0;
                        stg_len_next = '0;
                        ovf_next     = 1'b0;
                        state_next   = chr_pkg::ST_IDLE;
                    end
                end
            end

            // clip the recalled length
            chr_pkg::ST_STR_LEN:
            begin
                len_next  = stream_len;
                idx_next  = '0;
                pend_next = 1'b0;
                if (stream_len == '0)
                begin
                    state_next = chr_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = chr_pkg::ST_STREAM;
                end
            end

            // stream the selected entry, one character per transfer
            chr_pkg::ST_STREAM:
            begin
                issue = (idx_reg < len_reg) && (!pend_reg || can_load);
                if (issue)
                begin
                    line_re    = 1'b1;
                    line_raddr = {slot_reg, idx_reg[IDX_W-1:0]};
                    idx_next   = idx_reg + LEN_W'(1);
                end
                if (pend_reg && can_load)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = line_rdata;
                    out_kind_next  = chr_pkg::KIND_CHAR;
                    out_last_next  = (idx_reg == len_reg);
                    if (idx_reg == len_reg)
                    begin
                        state_next = chr_pkg::ST_IDLE;
                    end
                end
                pend_next = issue || (pend_reg && !can_load);
            end

            // cursor stepped past the newest entry
            chr_pkg::ST_EMPTY:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = '0;
                    out_kind_next  = chr_pkg::KIND_EMPTY;
                    out_last_next  = 1'b1;
                    state_next     = chr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = chr_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chr_pkg::ST_IDLE;
            idx_reg       <= '0;
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            stg_len_reg   <= '0;
            ovf_reg       <= 1'b0;
            count_reg     <= '0;
            ws_reg        <= '0;
            active_reg    <= 1'b0;
            pos_reg       <= '0;
            slot_reg      <= '0;
            cmax_reg      <= chr_pkg::CMAX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            stg_len_reg   <= stg_len_next;
            ovf_reg       <= ovf_next;
            count_reg     <= count_next;
            ws_reg        <= ws_next;
            active_reg    <= active_next;
            pos_reg       <= pos_next;
            slot_reg      <= slot_next;
            cmax_reg      <= cmax_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

FILE: sv/command_history_ring.sv
// command_history_ring: top level, sequencer plus staging, line and length rams
// depends on chr_pkg, chr_if, chr_ram and chr_seq
//
//   channel | dir | fields                          | transfer when
//   --------+-----+---------------------------------+---------------------
//   req     | in  | command, char_in                | req.valid & req.ready
//   rsp     | out | char_out, kind, last            | rsp.valid & rsp.ready
//   cfg     | in  | out_chars_max                   | cfg.valid & cfg.ready
//
// append, an empty commit and a recall with no effect leave the sequencer idle, ready next cycle
// commit of L chars: matching lengths run the byte compare on the shared index
// counter, which drops a duplicate and leads to the copy on a difference; else
// the copy runs alone, after the length check or with the compare skipped
// recall: streams the L chars of the entry, none when L is 0, or the empty-line marker
// rst_n clears control state asynchronously; a stalled rsp pauses the stream
`timescale 1ns / 1ps
`default_nettype none

module command_history_ring #(
    parameter int HISTORY_DEPTH = chr_pkg::HISTORY_DEPTH_DEF,
    parameter int LINE_BYTES    = chr_pkg::LINE_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    chr_req_if.sink   req,
    chr_rsp_if.source rsp,
    chr_cfg_if.sink   cfg
);

    localparam int LEN_W  = chr_pkg::len_width(LINE_BYTES);
    localparam int IDX_W  = chr_pkg::idx_width(LINE_BYTES);
    localparam int SLOT_W = chr_pkg::slot_width(HISTORY_DEPTH);

    logic                          stg_we;
    logic [IDX_W-1:0]              stg_waddr;
    logic [chr_pkg::CHAR_W-1:0]    stg_wdata;
    logic                          stg_re;
    logic [IDX_W-1:0]              stg_raddr;
    logic [chr_pkg::CHAR_W-1:0]    stg_rdata;
    logic                          line_we;
    logic [SLOT_W+IDX_W-1:0]       line_waddr;
    logic [chr_pkg::CHAR_W-1:0]    line_wdata;
    logic                          line_re;
    logic [SLOT_W+IDX_W-1:0]       line_raddr;
    logic [chr_pkg::CHAR_W-1:0]    line_rdata;
    logic                          len_we;
    logic [SLOT_W-1:0]             len_waddr;
    logic [LEN_W-1:0]              len_wdata;
    logic                          len_re;
    logic [SLOT_W-1:0]             len_raddr;
    logic [LEN_W-1:0]              len_rdata;

    // sequencer
    chr_seq #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .LINE_BYTES    (LINE_BYTES),
        .LEN_W         (LEN_W),
        .IDX_W         (IDX_W),
        .SLOT_W        (SLOT_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg        (cfg),
        .stg_we     (stg_we),
        .stg_waddr  (stg_waddr),
        .stg_wdata  (stg_wdata),
        .stg_re     (stg_re),
        .stg_raddr  (stg_raddr),
        .stg_rdata  (stg_rdata),
        .line_we    (line_we),
        .line_waddr (line_waddr),
        .line_wdata (line_wdata),
        .line_re    (line_re),
        .line_raddr (line_raddr),
        .line_rdata (line_rdata),
        .len_we     (len_we),
        .len_waddr  (len_waddr),
        .len_wdata  (len_wdata),
        .len_re     (len_re),
        .len_raddr  (len_raddr),
        .len_rdata  (len_rdata)
    );

    // staging line
    chr_ram #(
        .WIDTH  (chr_pkg::CHAR_W),
        .ADDR_W (IDX_W)
    ) u_stg_ram (
        .clk   (clk),
        .we    (stg_we),
        .waddr (stg_waddr),
        .wdata (stg_wdata),
        .re    (stg_re),
        .raddr (stg_raddr),
        .rdata (stg_rdata)
    );

    // line store, one row per ring slot
    chr_ram #(
        .WIDTH  (chr_pkg::CHAR_W),
        .ADDR_W (SLOT_W + IDX_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .re    (line_re),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // entry lengths
    chr_ram #(
        .WIDTH  (LEN_W),
        .ADDR_W (SLOT_W)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (len_re),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

endmodule

`default_nettype wire

FILE: sv/chr_checker.sv
// chr_checker: port-level assertions for the command history ring
// depends on chr_pkg; bound to command_history_ring at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module chr_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  logic [chr_pkg::CMD_W-1:0]     req_command,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic [chr_pkg::CHAR_W-1:0]    rsp_char_out,
    input  logic                          rsp_kind,
    input  logic                          rsp_last
);

    // a stalled result holds
    property p_rsp_hold;
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(rsp_char_out) && $stable(rsp_kind) && $stable(rsp_last);
    endproperty
    a_rsp_hold: assert property (p_rsp_hold)
        else $error("result changed while stalled");

    // the empty-line marker is a lone, zero, final result
    property p_empty_result;
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == chr_pkg::KIND_EMPTY) |->
            (rsp_char_out == '0) && rsp_last;
    endproperty
    a_empty_result: assert property (p_empty_result)
        else $error("empty-line result with data or not last");

    // recalled characters are never zero, since zero is never stored
    property p_char_nonzero;
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == chr_pkg::KIND_CHAR) |-> (rsp_char_out != '0);
    endproperty
    a_char_nonzero: assert property (p_char_nonzero)
        else $error("recalled character is zero");

    // an append transfer is followed by ready in the next cycle
    property p_append_fast;
        @(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_command == chr_pkg::CMD_APPEND) |=> req_ready;
    endproperty
    a_append_fast: assert property (p_append_fast)
        else $error("not ready after an append transfer");

    // a commit never starts a result
    property p_commit_silent;
        @(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_command == chr_pkg::CMD_COMMIT) |=>
            !$rose(rsp_valid);
    endproperty
    a_commit_silent: assert property (p_commit_silent)
        else $error("result raised after a commit transfer");

endmodule

bind command_history_ring chr_checker u_chr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_command  (req.command),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_char_out (rsp.char_out),
    .rsp_kind     (rsp.kind),
    .rsp_last     (rsp.last)
);

`default_nettype wire
